[design/plm_pkg.sv]
// ----------------------------------------------------------------------------
// plm_pkg: shared types and constants of the point list measurement engine
// Micro-op encoding, sequencer program, controller states and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package plm_pkg;

    localparam int VALUE_BITS = 52;
    localparam int ADDR_BITS  = 6;

    localparam logic [2:0] KIND_LENGTH   = 3'd0;
    localparam logic [2:0] KIND_PT_SEG   = 3'd1;
    localparam logic [2:0] KIND_DEPTH    = 3'd2;
    localparam logic [2:0] KIND_AREA     = 3'd3;
    localparam logic [2:0] KIND_POLYLINE = 3'd4;
    localparam logic [2:0] KIND_CLOSED   = 3'd5;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TOO_FEW   = 2'd1;
    localparam logic [1:0] STATUS_SATURATED = 2'd2;

    typedef logic [ADDR_BITS-1:0] addr_t;

    // program entry points
    localparam addr_t A_DIST_PF  = 6'd0;
    localparam addr_t A_DIST_PQ  = 6'd1;
    localparam addr_t A_DIST_FS  = 6'd2;
    localparam addr_t A_DIST_FP  = 6'd3;
    localparam addr_t A_DEPTH    = 6'd4;
    localparam addr_t A_TRI_FQP  = 6'd13;
    localparam addr_t A_TRI_FPS  = 6'd15;
    localparam addr_t A_PSEG     = 6'd36;
    localparam addr_t A_PSEG_DIV = 6'd48;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_END,
        UOP_LOADU,
        UOP_LOADV,
        UOP_CLR,
        UOP_MAC,
        UOP_MOVC,
        UOP_MOVDD,
        UOP_SQRT,
        UOP_DIV,
        UOP_ADDR,
        UOP_ADDRH,
        UOP_ADDZ,
        UOP_CHECK,
        UOP_JSEL
    } uop_t;

    typedef enum logic [1:0] {
        PS_F,
        PS_S,
        PS_Q,
        PS_P
    } pnt_sel_t;

    typedef enum logic [3:0] {
        OS_U0,
        OS_U1,
        OS_U2,
        OS_V0,
        OS_V1,
        OS_V2,
        OS_C0,
        OS_C1,
        OS_C2
    } opnd_sel_t;

    typedef enum logic [1:0] {
        UNIT_NONE,
        UNIT_MAC,
        UNIT_SQRT,
        UNIT_DIV
    } unit_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_EXEC,
        ST_WAIT,
        ST_COMMIT,
        ST_REPORT
    } state_t;

    typedef struct packed {
        uop_t      op;
        pnt_sel_t  pa;
        pnt_sel_t  pb;
        opnd_sel_t oa;
        opnd_sel_t ob;
        logic      neg;
        addr_t     nxt;
    } uinst_t;

    typedef struct packed {
        uop_t       op;
        pnt_sel_t   pa;
        pnt_sel_t   pb;
        opnd_sel_t  oa;
        opnd_sel_t  ob;
        logic       neg;
        logic       accept;
        logic       first;
        logic       commit;
        logic       set_second;
        logic       report;
        logic       too_few;
        logic [2:0] kind;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic near_start;
        logic past_end;
        logic out_free;
    } dp_stat_t;

    function automatic uinst_t mk(uop_t op, pnt_sel_t pa, pnt_sel_t pb,
                                  opnd_sel_t oa, opnd_sel_t ob, logic neg, addr_t nxt);
        uinst_t u;
        u.op  = op;
        u.pa  = pa;
        u.pb  = pb;
        u.oa  = oa;
        u.ob  = ob;
        u.neg = neg;
        u.nxt = nxt;
        return u;
    endfunction

    // sequencer program
    function automatic uinst_t prog(addr_t a);
        uinst_t u;
        case (a)
            6'd0:  u = mk(UOP_LOADU, PS_P, PS_F, OS_U0, OS_U0, 1'b0, 6'd5);
            6'd1:  u = mk(UOP_LOADU, PS_P, PS_Q, OS_U0, OS_U0, 1'b0, 6'd5);
            6'd2:  u = mk(UOP_LOADU, PS_F, PS_S, OS_U0, OS_U0, 1'b0, 6'd5);
            6'd3:  u = mk(UOP_LOADU, PS_F, PS_P, OS_U0, OS_U0, 1'b0, 6'd5);
            6'd4:  u = mk(UOP_LOADU, PS_P, PS_F, OS_U0, OS_U0, 1'b0, 6'd11);
            6'd5:  u = mk(UOP_CLR,   PS_F, PS_F, OS_U0, OS_U0, 1'b0, 6'd6);
            6'd6:  u = mk(UOP_MAC,   PS_F, PS_F, OS_U0, OS_U0, 1'b0, 6'd7);
            6'd7:  u = mk(UOP_MAC,   PS_F, PS_F, OS_U1, OS_U1, 1'b0, 6'd8);
            6'd8:  u = mk(UOP_MAC,   PS_F, PS_F, OS_U2, OS_U2, 1'b0, 6'd9);
            6'd9:  u = mk(UOP_SQRT,  PS_F, PS_F, OS_U0, OS_U0, 1'b0, 6'd10);
            6'd10: u = mk(UOP_ADDR,  PS_F, PS_F, OS_U0, OS_U0, 1'b0, 6'd12);
            6'd11: u = mk(UOP_ADDZ,  PS_F, PS_F, OS_U0, OS_U0, 1'b0, 6'd12);
            6'd12: u = mk(UOP_END,   PS_F, PS_F, OS_U0, OS_U0, 1'b0, 6'd12);
            6'd13: u = mk(UOP_LOADU, PS_Q, PS_F, OS_U0, OS_U0, 1'b0, 6'd14);
            6'd14: u = mk(UOP_LOADV, PS_P, PS_F, OS_U0, OS_U0, 1'b0, 6'd17);
            6'd15: u = mk(UOP_LOADU, PS_P, PS_F, OS_U0, OS_U0, 1'b0, 6'd16);
            6'd16: u = mk(UOP_LOADV, PS_S, PS_F, OS_U0, OS_U0, 1'b0, 6'd17);
            6'd17: u = mk(UOP_CLR,   PS_F, PS_F, OS_U0, OS_U0, 1'b0, 6'd18);
            6'd18: u = mk(UOP_MAC,   PS_F, PS_F, OS_U1, OS_V2, 1'b0, 6'd19);
            6'd19: u = mk(UOP_MAC,   PS_F, PS_F, OS_U2, OS_V1, 1'b1, 6'd20);
            6'd20: u = mk(UOP_MOVC,  PS_F, PS_F, OS_C0, OS_U0, 1'b0, 6'd21);
            6'd21: u = mk(UOP_CLR,   PS_F, PS_F, OS_U0, OS_U0, 1'b0, 6'd22);
            6'd22: u = mk(UOP_MAC,   PS_F, PS_F, OS_U2, OS_V0, 1'b0, 6'd23);
            6'd23: u = mk(UOP_MAC,   PS_F, PS_F, OS_U0, OS_V2, 1'b1, 6'd24);
            6'd24: u = mk(UOP_MOVC,  PS_F, PS_F, OS_C1, OS_U0, 1'b0, 6'd25);
            6'd25: u = mk(UOP_CLR,   PS_F, PS_F, OS_U0, OS_U0, 1'b0, 6'd26);
            6'd26: u = mk(UOP_MAC,   PS_F, PS_F, OS_U0, OS_V1, 1'b0, 6'd27);
            6'd27: u = mk(UOP_MAC,   PS_F, PS_F, OS_U1, OS_V0, 1'b1, 6'd28);
            6'd28: u = mk(UOP_MOVC,  PS_F, PS_F, OS_C2, OS_U0, 1'b0, 6'd29);
            6'd29: u = mk(UOP_CLR,   PS_F, PS_F, OS_U0, OS_U0, 1'b0, 6'd30);
            6'd30: u = mk(UOP_MAC,   PS_F, PS_F, OS_C0, OS_C0, 1'b0, 6'd31);
            6'd31: u = mk(UOP_MAC,   PS_F, PS_F, OS_C1, OS_C1, 1'b0, 6'd32);
            6'd32: u = mk(UOP_MAC,   PS_F, PS_F, OS_C2, OS_C2, 1'b0, 6'd33);
            6'd33: u = mk(UOP_JSEL,  PS_F, PS_F, OS_U0, OS_U0, 1'b0, 6'd34);
            6'd34: u = mk(UOP_SQRT,  PS_F, PS_F, OS_U0, OS_U0, 1'b0, 6'd35);
            6'd35: u = mk(UOP_ADDRH, PS_F, PS_F, OS_U0, OS_U0, 1'b0, 6'd12);
            6'd36: u = mk(UOP_LOADV, PS_P, PS_S, OS_U0, OS_U0, 1'b0, 6'd37);
            6'd37: u = mk(UOP_LOADU, PS_F, PS_S, OS_U0, OS_U0, 1'b0, 6'd38);
            6'd38: u = mk(UOP_CLR,   PS_F, PS_F, OS_U0, OS_U0, 1'b0, 6'd39);
            6'd39: u = mk(UOP_MAC,   PS_F, PS_F, OS_V0, OS_V0, 1'b0, 6'd40);
            6'd40: u = mk(UOP_MAC,   PS_F, PS_F, OS_V1, OS_V1, 1'b0, 6'd41);
            6'd41: u = mk(UOP_MAC,   PS_F, PS_F, OS_V2, OS_V2, 1'b0, 6'd42);
            6'd42: u = mk(UOP_MOVDD, PS_F, PS_F, OS_U0, OS_U0, 1'b0, 6'd43);
            6'd43: u = mk(UOP_CLR,   PS_F, PS_F, OS_U0, OS_U0, 1'b0, 6'd44);
            6'd44: u = mk(UOP_MAC,   PS_F, PS_F, OS_U0, OS_V0, 1'b0, 6'd45);
            6'd45: u = mk(UOP_MAC,   PS_F, PS_F, OS_U1, OS_V1, 1'b0, 6'd46);
            6'd46: u = mk(UOP_MAC,   PS_F, PS_F, OS_U2, OS_V2, 1'b0, 6'd47);
            6'd47: u = mk(UOP_CHECK, PS_F, PS_F, OS_U0, OS_U0, 1'b0, 6'd17);
            6'd48: u = mk(UOP_DIV,   PS_F, PS_F, OS_U0, OS_U0, 1'b0, 6'd49);
            6'd49: u = mk(UOP_SQRT,  PS_F, PS_F, OS_U0, OS_U0, 1'b0, 6'd50);
            6'd50: u = mk(UOP_ADDR,  PS_F, PS_F, OS_U0, OS_U0, 1'b0, 6'd12);
            default: u = mk(UOP_END, PS_F, PS_F, OS_U0, OS_U0, 1'b0, 6'd12);
        endcase
        return u;
    endfunction

endpackage

[design/plm_dpath.sv]
// ----------------------------------------------------------------------------
// plm_dpath: point list measurement datapath
// Point registers, difference vectors, a shift-add multiply-accumulate unit,
// a digit-by-digit square root, a restoring divider, the saturating running
// sum and the result register.
// ----------------------------------------------------------------------------
module plm_dpath #(
    parameter int COORD_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  plm_pkg::dp_cmd_t              cmd,
    output plm_pkg::dp_stat_t             stat,
    input  logic signed [COORD_BITS-1:0]  coord_x,
    input  logic signed [COORD_BITS-1:0]  coord_y,
    input  logic signed [COORD_BITS-1:0]  coord_z,
    output logic [plm_pkg::VALUE_BITS-1:0] m_value,
    output logic [1:0]                    m_status,
    output logic [2:0]                    m_kind_echo,
    output logic                          m_valid,
    input  logic                          m_ready
);
    import plm_pkg::*;

    localparam int DW = COORD_BITS + 1;     // coordinate difference
    localparam int MW = 2 * DW + 1;         // multiplier operand, cross component
    localparam int PW = 2 * MW;             // product, radicand
    localparam int AW = PW + 1;             // signed accumulator
    localparam int CW = $clog2(PW + 1);
    localparam int EW = ((MW > VALUE_BITS) ? MW : VALUE_BITS) + 1;
    localparam logic [EW-1:0] VMAX = EW'({VALUE_BITS{1'b1}});

    logic signed [COORD_BITS-1:0] p_reg [3];
    logic signed [COORD_BITS-1:0] f_reg [3];
    logic signed [COORD_BITS-1:0] s_reg [3];
    logic signed [COORD_BITS-1:0] q_reg [3];
    logic signed [DW-1:0]         u_reg [3];
    logic signed [DW-1:0]         v_reg [3];
    logic signed [MW-1:0]         c_reg [3];
    logic signed [AW-1:0]         acc_reg;
    logic [PW-1:0]                dd_reg;
    logic [MW-1:0]                r_reg;
    logic [MW+1:0]                rem_reg;
    logic [PW:0]                  drem_reg;
    logic [MW-1:0]                ma_reg;
    logic [PW-1:0]                prod_reg;
    logic                         mneg_reg;
    logic [CW-1:0]                cnt_reg;
    unit_t                        unit_reg;
    logic [VALUE_BITS-1:0]        sum_reg;
    logic                         sat_reg;
    logic [VALUE_BITS-1:0]        value_reg;
    logic [1:0]                   status_reg;
    logic [2:0]                   kind_reg;
    logic                         valid_reg;

    logic signed [COORD_BITS-1:0] pa [3];
    logic signed [COORD_BITS-1:0] pb [3];
    logic signed [MW-1:0]         oa;
    logic signed [MW-1:0]         ob;
    logic [MW-1:0]                a_mag;
    logic [MW-1:0]                b_mag;
    logic [MW:0]                  mt;
    logic [MW+2:0]                rem_sh;
    logic [MW+2:0]                trial;
    logic [MW+2:0]                rem_dif;
    logic                         sq_ge;
    logic [PW:0]                  dsh;
    logic                         d_ge;
    logic [DW-1:0]                z_abs;
    logic [MW-1:0]                add_x;
    logic [EW-1:0]                add_tot;
    logic                         add_sat;

    always_comb begin
        case (cmd.pa)
            PS_F:    pa = f_reg;
            PS_S:    pa = s_reg;
            PS_Q:    pa = q_reg;
            default: pa = p_reg;
        endcase
        case (cmd.pb)
            PS_F:    pb = f_reg;
            PS_S:    pb = s_reg;
            PS_Q:    pb = q_reg;
            default: pb = p_reg;
        endcase
    end

    function automatic logic signed [MW-1:0] opnd(
        opnd_sel_t sel,
        logic signed [DW-1:0] u0, logic signed [DW-1:0] u1, logic signed [DW-1:0] u2,
        logic signed [DW-1:0] v0, logic signed [DW-1:0] v1, logic signed [DW-1:0] v2,
        logic signed [MW-1:0] c0, logic signed [MW-1:0] c1, logic signed [MW-1:0] c2);
        logic signed [MW-1:0] r;
        case (sel)
            OS_U0:   r = MW'(u0);
            OS_U1:   r = MW'(u1);
            OS_U2:   r = MW'(u2);
            OS_V0:   r = MW'(v0);
            OS_V1:   r = MW'(v1);
            OS_V2:   r = MW'(v2);
            OS_C0:   r = c0;
            OS_C1:   r = c1;
            default: r = c2;
        endcase
        return r;
    endfunction

    always_comb begin
        oa = opnd(cmd.oa, u_reg[0], u_reg[1], u_reg[2], v_reg[0], v_reg[1], v_reg[2],
                  c_reg[0], c_reg[1], c_reg[2]);
        ob = opnd(cmd.ob, u_reg[0], u_reg[1], u_reg[2], v_reg[0], v_reg[1], v_reg[2],
                  c_reg[0], c_reg[1], c_reg[2]);
        a_mag = oa[MW-1] ? MW'(-oa) : MW'(oa);
        b_mag = ob[MW-1] ? MW'(-ob) : MW'(ob);

        mt = {1'b0, prod_reg[PW-1:MW]} + (prod_reg[0] ? {1'b0, ma_reg} : {(MW+1){1'b0}});

        rem_sh  = {rem_reg[MW:0], acc_reg[PW-1:PW-2]};
        trial   = {1'b0, r_reg, 2'b01};
        rem_dif = rem_sh - trial;
        sq_ge   = (rem_sh >= trial);

        dsh  = {drem_reg[PW-1:0], acc_reg[PW-1]};
        d_ge = (dsh >= {1'b0, dd_reg});

        z_abs = u_reg[2][DW-1] ? DW'(-u_reg[2]) : DW'(u_reg[2]);
        case (cmd.op)
            UOP_ADDRH: add_x = r_reg >> 1;
            UOP_ADDZ:  add_x = MW'(z_abs);
            default:   add_x = r_reg;
        endcase
        add_tot = EW'(sum_reg) + EW'(add_x);
        add_sat = (EW'(add_x) > VMAX) || (add_tot > VMAX);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_reg  <= UNIT_NONE;
            sum_reg   <= '0;
            sat_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                p_reg[0] <= coord_x;
                p_reg[1] <= coord_y;
                p_reg[2] <= coord_z;
                if (cmd.first) begin
                    f_reg[0] <= coord_x;
                    f_reg[1] <= coord_y;
                    f_reg[2] <= coord_z;
                end
            end
            if (cmd.commit) begin
                q_reg <= p_reg;
                if (cmd.set_second) begin
                    s_reg <= p_reg;
                end
            end

            case (cmd.op)
                UOP_LOADU: begin
                    for (int i = 0; i < 3; i++) begin
                        u_reg[i] <= DW'(pa[i]) - DW'(pb[i]);
                    end
                end
                UOP_LOADV: begin
                    for (int i = 0; i < 3; i++) begin
                        v_reg[i] <= DW'(pa[i]) - DW'(pb[i]);
                    end
                end
                UOP_CLR: begin
                    acc_reg <= '0;
                end
                UOP_MOVC: begin
                    case (cmd.oa)
                        OS_C0:   c_reg[0] <= acc_reg[MW-1:0];
                        OS_C1:   c_reg[1] <= acc_reg[MW-1:0];
                        default: c_reg[2] <= acc_reg[MW-1:0];
                    endcase
                end
                UOP_MOVDD: begin
                    dd_reg <= acc_reg[PW-1:0];
                end
                UOP_MAC: begin
                    ma_reg   <= a_mag;
                    prod_reg <= {{MW{1'b0}}, b_mag};
                    mneg_reg <= oa[MW-1] ^ ob[MW-1] ^ cmd.neg;
                    cnt_reg  <= '0;
                    unit_reg <= UNIT_MAC;
                end
                UOP_SQRT: begin
                    rem_reg  <= '0;
                    r_reg    <= '0;
                    cnt_reg  <= '0;
                    unit_reg <= UNIT_SQRT;
                end
                UOP_DIV: begin
                    drem_reg <= '0;
                    cnt_reg  <= '0;
                    unit_reg <= UNIT_DIV;
                end
                UOP_ADDR, UOP_ADDRH, UOP_ADDZ: begin
                    if (add_sat) begin
                        sum_reg <= VMAX[VALUE_BITS-1:0];
                        sat_reg <= 1'b1;
                    end else begin
                        sum_reg <= add_tot[VALUE_BITS-1:0];
                    end
                end
                default: begin
                end
            endcase

            case (unit_reg)
                UNIT_MAC: begin
                    if (cnt_reg == CW'(MW)) begin
                        // fold the finished product into the accumulator
                        if (mneg_reg) begin
                            acc_reg <= acc_reg - signed'({1'b0, prod_reg});
                        end else begin
                            acc_reg <= acc_reg + signed'({1'b0, prod_reg});
                        end
                        unit_reg <= UNIT_NONE;
                    end else begin
                        prod_reg <= {mt, prod_reg[MW-1:1]};
                        cnt_reg  <= cnt_reg + 1'b1;
                    end
                end
                UNIT_SQRT: begin
                    rem_reg <= sq_ge ? rem_dif[MW+1:0] : rem_sh[MW+1:0];
                    r_reg   <= {r_reg[MW-2:0], sq_ge};
                    acc_reg <= {1'b0, acc_reg[PW-3:0], 2'b00};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(MW - 1)) begin
                        unit_reg <= UNIT_NONE;
                    end
                end
                UNIT_DIV: begin
                    drem_reg <= d_ge ? (dsh - {1'b0, dd_reg}) : dsh;
                    acc_reg  <= {1'b0, acc_reg[PW-2:0], d_ge};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(PW - 1)) begin
                        unit_reg <= UNIT_NONE;
                    end
                end
                default: begin
                end
            endcase

            if (cmd.report) begin
                value_reg  <= cmd.too_few ? '0 : sum_reg;
                status_reg <= cmd.too_few ? STATUS_TOO_FEW :
                              (sat_reg ? STATUS_SATURATED : STATUS_OK);
                kind_reg   <= cmd.kind;
                valid_reg  <= 1'b1;
                sum_reg    <= '0;
                sat_reg    <= 1'b0;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        stat.busy       = (unit_reg != UNIT_NONE);
        stat.near_start = (dd_reg == '0) || acc_reg[AW-1] || (acc_reg == '0);
        stat.past_end   = !acc_reg[AW-1] && (acc_reg[PW-1:0] >= dd_reg);
        stat.out_free   = !valid_reg || m_ready;
    end

    assign m_value     = value_reg;
    assign m_status    = status_reg;
    assign m_kind_echo = kind_reg;
    assign m_valid     = valid_reg;

endmodule

[design/plm_ctrl.sv]
// ----------------------------------------------------------------------------
// plm_ctrl: point list measurement controller
// Handshake, point count and list kind, and a sequencer that steps the
// datapath through the program for each point that has a task and for the closing triangle.
// ----------------------------------------------------------------------------
module plm_ctrl #(
    parameter int COUNT_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_measure_kind,
    input  logic              s_last_point,
    input  plm_pkg::dp_stat_t stat,
    output plm_pkg::dp_cmd_t  cmd
);
    import plm_pkg::*;

    state_t                state_reg, state_next;
    addr_t                 pc_reg, pc_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [2:0]            kind_reg, kind_next;
    logic                  last_reg, last_next;
    logic                  pseg_reg, pseg_next;
    logic                  closing_reg, closing_next;

    uinst_t                ui;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  too_few;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pc_reg      <= '0;
            count_reg   <= '0;
            kind_reg    <= '0;
            last_reg    <= 1'b0;
            pseg_reg    <= 1'b0;
            closing_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            count_reg   <= count_next;
            kind_reg    <= kind_next;
            last_reg    <= last_next;
            pseg_reg    <= pseg_next;
            closing_reg <= closing_next;
        end
    end

    always_comb begin
        ui        = prog(pc_reg);
        count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;

        case (kind_reg)
            KIND_LENGTH, KIND_DEPTH, KIND_POLYLINE: too_few = (count_reg < COUNT_BITS'(2));
            KIND_PT_SEG, KIND_AREA, KIND_CLOSED:    too_few = (count_reg < COUNT_BITS'(3));
            default:                                too_few = 1'b1;
        endcase

        state_next   = state_reg;
        pc_next      = pc_reg;
        count_next   = count_reg;
        kind_next    = kind_reg;
        last_next    = last_reg;
        pseg_next    = pseg_reg;
        closing_next = closing_reg;

        s_ready        = 1'b0;
        cmd.op         = UOP_NOP;
        cmd.pa         = ui.pa;
        cmd.pb         = ui.pb;
        cmd.oa         = ui.oa;
        cmd.ob         = ui.ob;
        cmd.neg        = ui.neg;
        cmd.accept     = 1'b0;
        cmd.first      = 1'b0;
        cmd.commit     = 1'b0;
        cmd.set_second = 1'b0;
        cmd.report     = 1'b0;
        cmd.too_few    = too_few;
        cmd.kind       = kind_reg;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    cmd.first  = (count_reg == '0);
                    if (count_reg == '0) begin
                        kind_next = s_measure_kind;
                    end
                    last_next  = s_last_point;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                // pick the per-point task from the kind and this point's index
                state_next = ST_EXEC;
                pseg_next  = 1'b0;
                case (kind_reg)
                    KIND_LENGTH: begin
                        if (count_reg == COUNT_BITS'(1)) pc_next = A_DIST_PF;
                        else state_next = ST_COMMIT;
                    end
                    KIND_DEPTH: begin
                        if (count_reg == COUNT_BITS'(1)) pc_next = A_DEPTH;
                        else state_next = ST_COMMIT;
                    end
                    KIND_PT_SEG: begin
                        if (count_reg == COUNT_BITS'(2)) begin
                            pc_next   = A_PSEG;
                            pseg_next = 1'b1;
                        end else begin
                            state_next = ST_COMMIT;
                        end
                    end
                    KIND_AREA, KIND_CLOSED: begin
                        if (count_reg >= COUNT_BITS'(2)) pc_next = A_TRI_FQP;
                        else state_next = ST_COMMIT;
                    end
                    KIND_POLYLINE: begin
                        if (count_reg >= COUNT_BITS'(1)) pc_next = A_DIST_PQ;
                        else state_next = ST_COMMIT;
                    end
                    default: begin
                        state_next = ST_COMMIT;
                    end
                endcase
            end
            ST_EXEC: begin
                cmd.op = ui.op;
                case (ui.op)
                    UOP_END: begin
                        state_next = closing_reg ? ST_REPORT : ST_COMMIT;
                    end
                    UOP_MAC, UOP_SQRT, UOP_DIV: begin
                        state_next = ST_WAIT;
                    end
                    UOP_CHECK: begin
                        if (stat.near_start)    pc_next = A_DIST_FS;
                        else if (stat.past_end) pc_next = A_DIST_FP;
                        else                    pc_next = ui.nxt;
                    end
                    UOP_JSEL: begin
                        pc_next = pseg_reg ? A_PSEG_DIV : ui.nxt;
                    end
                    default: begin
                        pc_next = ui.nxt;
                    end
                endcase
            end
            ST_WAIT: begin
                if (!stat.busy) begin
                    pc_next    = ui.nxt;
                    state_next = ST_EXEC;
                end
            end
            ST_COMMIT: begin
                cmd.commit     = 1'b1;
                cmd.set_second = (count_reg == COUNT_BITS'(1));
                count_next     = count_inc;
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (kind_reg == KIND_CLOSED && count_inc >= COUNT_BITS'(4)) begin
                    // closing triangle first, last, second
                    closing_next = 1'b1;
                    pseg_next    = 1'b0;
                    pc_next      = A_TRI_FPS;
                    state_next   = ST_EXEC;
                end else begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (stat.out_free) begin
                    cmd.report   = 1'b1;
                    count_next   = '0;
                    closing_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/point_list_measurement_engine.sv]
// ----------------------------------------------------------------------------
// point_list_measurement_engine: 3D point list length, distance and area
// One point per transaction; a point with last_point set yields one result.
// ----------------------------------------------------------------------------
// One point at a time: a new point is taken only once the last one is done.
// Work per point is a distance, a depth, a triangle or a point-to-segment
// distance, run on the bit-serial multiplier (M = 2*COORD_BITS+3 bit
// operands), the square root and the divider; a point may need no work.
// A last point adds a report step, plus a closing triangle for a closed fan.
// Synchronous active-low reset clears the count, kind, sum and handshakes.
module point_list_measurement_engine #(
    parameter int COORD_BITS = 24,
    parameter int COUNT_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [COORD_BITS-1:0]   s_coord_x,
    input  logic signed [COORD_BITS-1:0]   s_coord_y,
    input  logic signed [COORD_BITS-1:0]   s_coord_z,
    input  logic [2:0]                     s_measure_kind,
    input  logic                           s_last_point,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [plm_pkg::VALUE_BITS-1:0] m_value,
    output logic [1:0]                     m_status,
    output logic [2:0]                     m_kind_echo
);
    import plm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    plm_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_measure_kind (s_measure_kind),
        .s_last_point   (s_last_point),
        .stat           (stat),
        .cmd            (cmd)
    );

    plm_dpath #(
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .coord_x     (s_coord_x),
        .coord_y     (s_coord_y),
        .coord_z     (s_coord_z),
        .m_value     (m_value),
        .m_status    (m_status),
        .m_kind_echo (m_kind_echo),
        .m_valid     (m_valid),
        .m_ready     (m_ready)
    );

endmodule

[bench/point_list_measurement_engine_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_list_measurement_engine_test: self-checking bench for the engine
// Streams 3D point lists of every measurement kind through the valid/ready
// input with random gaps and output back-pressure. An exact integer predictor
// computes each list's value, status and kind, and checks every result.
// ----------------------------------------------------------------------------
module point_list_measurement_engine_test;
    import plm_pkg::*;

    localparam int CW = 24;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;
    localparam logic [127:0] VALUE_CAP = (128'd1 << VALUE_BITS) - 1;
    localparam int COUNT_CAP = 65535;
    localparam longint CYCLE_LIMIT = 10000000;
    localparam int RANDOM_POINTS = 1200;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic [1:0] status;
        logic [2:0] kind;
    } result_t;

    typedef struct {
        coord_t x, y, z;
        logic [2:0] kind;
        logic last;
        logic typed;
        logic [VALUE_BITS-1:0] value;
        logic [1:0] status;
    } row_t;

    logic aclk, aresetn;
    logic s_valid, s_ready, s_last_point;
    coord_t s_coord_x, s_coord_y, s_coord_z;
    logic [2:0] s_measure_kind;
    logic m_valid, m_ready;
    logic [VALUE_BITS-1:0] m_value;
    logic [1:0] m_status;
    logic [2:0] m_kind_echo;

    result_t expected_q[$];
    row_t directed_rows[$];
    int errors = 0;
    int results_seen = 0;
    int lists_sent = 0;
    int points_sent = 0;
    int saturated_seen = 0;
    bit no_gap = 0;
    longint cycles = 0;

    // measurement state mirrored from the block
    coord_t pt_first[3], pt_second[3], pt_prev[3];
    int unsigned pt_count;
    logic [127:0] meas_sum;
    logic [2:0] meas_kind;
    bit meas_sat;

    point_list_measurement_engine u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_coord_x(s_coord_x), .s_coord_y(s_coord_y), .s_coord_z(s_coord_z),
        .s_measure_kind(s_measure_kind), .s_last_point(s_last_point),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_value(m_value), .m_status(m_status), .m_kind_echo(m_kind_echo)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     expected_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [127:0] isqrt(logic [127:0] n);
        logic [127:0] r, t;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (128'd1 << b);
            if (t * t <= n) r = t;
        end
        return r;
    endfunction

    function automatic wide_t dot3(wide_t a[3], wide_t b[3]);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function automatic wide_t cross_sq(wide_t u[3], wide_t v[3]);
        wide_t cx, cy, cz;
        cx = u[1] * v[2] - u[2] * v[1];
        cy = u[2] * v[0] - u[0] * v[2];
        cz = u[0] * v[1] - u[1] * v[0];
        return cx * cx + cy * cy + cz * cz;
    endfunction

    function automatic void diff3(output wide_t d[3], input coord_t a[3], input coord_t b[3]);
        for (int i = 0; i < 3; i++) d[i] = wide_t'(a[i]) - wide_t'(b[i]);
    endfunction

    function automatic logic [127:0] span(coord_t a[3], coord_t b[3]);
        wide_t d[3];
        diff3(d, a, b);
        return isqrt(dot3(d, d));
    endfunction

    function automatic logic [127:0] tri_area(coord_t o[3], coord_t a[3], coord_t b[3]);
        wide_t u[3], v[3];
        diff3(u, a, o);
        diff3(v, b, o);
        return isqrt(cross_sq(u, v)) >> 1;
    endfunction

    // distance from p to segment a-b; degenerate segment falls back to |p-a|
    function automatic logic [127:0] seg_distance(coord_t p[3], coord_t a[3], coord_t b[3]);
        wide_t v[3], w[3], vv, wv;
        diff3(v, b, a);
        diff3(w, p, a);
        vv = dot3(v, v);
        wv = dot3(w, v);
        if (vv == 0 || wv <= 0) return span(p, a);
        if (wv >= vv) return span(p, b);
        return isqrt(cross_sq(w, v) / vv);
    endfunction

    function automatic void accumulate(logic [127:0] x);
        if (x > VALUE_CAP || meas_sum + x > VALUE_CAP) begin
            meas_sum = VALUE_CAP;
            meas_sat = 1;
        end else begin
            meas_sum = meas_sum + x;
        end
    endfunction

    // advance the mirrored state by one point; returns 1 with a result on a last point
    function automatic bit measure_point(coord_t x, coord_t y, coord_t z, logic [2:0] kind,
                                         logic last, output result_t res);
        coord_t p[3];
        int unsigned idx, need;
        wide_t dz;
        p[0] = x; p[1] = y; p[2] = z;
        idx = pt_count;
        if (idx == 0) begin
            meas_kind = kind;
            pt_first = p;
            meas_sum = 0;
            meas_sat = 0;
        end
        case (meas_kind)
            KIND_LENGTH: if (idx == 1) accumulate(span(p, pt_first));
            KIND_DEPTH: if (idx == 1) begin
                dz = wide_t'(p[2]) - wide_t'(pt_first[2]);
                accumulate(dz < 0 ? -dz : dz);
            end
            KIND_PT_SEG: if (idx == 2) accumulate(seg_distance(pt_first, pt_second, p));
            KIND_AREA, KIND_CLOSED: if (idx >= 2) accumulate(tri_area(pt_first, pt_prev, p));
            KIND_POLYLINE: if (idx >= 1) accumulate(span(p, pt_prev));
            default: ;
        endcase
        if (idx == 1) pt_second = p;
        pt_prev = p;
        if (pt_count < COUNT_CAP) pt_count++;
        if (!last) return 0;
        if (meas_kind == KIND_CLOSED && pt_count >= 4)
            accumulate(tri_area(pt_first, p, pt_second));
        case (meas_kind)
            KIND_LENGTH, KIND_DEPTH, KIND_POLYLINE: need = 2;
            KIND_PT_SEG, KIND_AREA, KIND_CLOSED: need = 3;
            default: need = 0;
        endcase
        if (need == 0 || pt_count < need) begin
            res.value = 0;
            res.status = STATUS_TOO_FEW;
        end else begin
            res.value = meas_sum[VALUE_BITS-1:0];
            res.status = meas_sat ? STATUS_SATURATED : STATUS_OK;
        end
        res.kind = meas_kind;
        pt_count = 0;
        meas_sum = 0;
        meas_sat = 0;
        return 1;
    endfunction

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, field, got, want);
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_status == STATUS_SATURATED) saturated_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("unexpected result at cycle %0d: value %0d", cycles, m_value);
            end else begin
                want = expected_q.pop_front();
                if (m_value !== want.value) report("value", m_value, want.value);
                if (m_status !== want.status) report("status", m_status, want.status);
                if (m_kind_echo !== want.kind) report("kind_echo", m_kind_echo, want.kind);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_gap || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_point(coord_t x, coord_t y, coord_t z, logic [2:0] kind,
                              logic last, logic typed = 0,
                              logic [VALUE_BITS-1:0] tv = 0, logic [1:0] ts = 0);
        result_t res;
        int gap;
        @(negedge aclk);
        s_valid = 1;
        s_coord_x = x; s_coord_y = y; s_coord_z = z;
        s_measure_kind = kind;
        s_last_point = last;
        do @(posedge aclk); while (!s_ready);
        points_sent++;
        if (measure_point(x, y, z, kind, last, res)) begin
            lists_sent++;
            if (typed) begin
                res.value = tv;
                res.status = ts;
            end
            expected_q.push_back(res);
        end
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic add_row(coord_t x, coord_t y, coord_t z, logic [2:0] kind, logic last,
                           logic typed = 0, logic [VALUE_BITS-1:0] v = 0,
                           logic [1:0] st = STATUS_OK);
        row_t r;
        r.x = x; r.y = y; r.z = z; r.kind = kind; r.last = last;
        r.typed = typed; r.value = v; r.status = st;
        directed_rows.push_back(r);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(5))
            0: return coord_t'($urandom_range(1) ? 24'h7FFFFF : 24'h800000);
            1, 2: return coord_t'($signed($urandom_range(400)) - 200);
            3: return coord_t'($urandom_range(1) ? 24'h7FFFF0 + $urandom_range(15)
                                                : 24'h800000 + $urandom_range(15));
            default: return coord_t'($urandom);
        endcase
    endfunction

    // receiver: random back-pressure with one long hold-off once results flow
    initial begin
        int r;
        bit held;
        bit steady;
        held = 0;
        steady = 0;
        m_ready = 0;
        forever begin
            @(negedge aclk);
            if (!held && results_seen >= 30) begin
                held = 1;
                m_ready = 0;
                repeat (3000) @(negedge aclk);
            end
            r = $urandom_range(99);
            if (r < 3) steady = ~steady;
            if (steady) begin
                m_ready = 1;
            end else if (r < 5) begin
                m_ready = 0;
                repeat ($urandom_range(20, 80)) @(negedge aclk);
            end else begin
                m_ready = (r < 75);
            end
        end
    end

    initial begin
        row_t r;
        int n, kind_pick, drain;
        logic [2:0] k;
        s_valid = 0;
        s_coord_x = 0; s_coord_y = 0; s_coord_z = 0;
        s_measure_kind = KIND_LENGTH;
        s_last_point = 0;
        pt_count = 0; meas_sum = 0; meas_kind = 0; meas_sat = 0;
        aresetn = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        add_row(0, 0, 0, KIND_LENGTH, 1, 1, 0, STATUS_TOO_FEW);
        add_row(0, 0, 0, KIND_LENGTH, 0);
        add_row(3, 4, 0, KIND_LENGTH, 1, 1, 5, STATUS_OK);
        add_row(24'sh800000, 24'sh800000, 24'sh800000, KIND_LENGTH, 0);
        add_row(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, KIND_LENGTH, 1);
        add_row(0, 0, 24'sh800000, KIND_DEPTH, 0);
        add_row(5, 9, 24'sh7FFFFF, KIND_DEPTH, 0);
        add_row(1, 1, 1, KIND_DEPTH, 1, 1, 24'hFFFFFF, STATUS_OK);
        // point to segment with a degenerate segment, plus an ignored extra point
        add_row(10, 0, 0, KIND_PT_SEG, 0);
        add_row(4, 0, 0, KIND_PT_SEG, 0);
        add_row(4, 0, 0, KIND_PT_SEG, 0);
        add_row(24'sh7FFFFF, 0, 0, KIND_PT_SEG, 1, 1, 6, STATUS_OK);
        add_row(0, 0, 0, KIND_PT_SEG, 0);
        add_row(7, 7, 7, KIND_PT_SEG, 1, 1, 0, STATUS_TOO_FEW);
        // fan area over full-scale corner coordinates
        add_row(24'sh800000, 24'sh800000, 0, KIND_AREA, 0);
        add_row(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, KIND_AREA, 0);
        add_row(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, KIND_AREA, 0);
        add_row(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, KIND_AREA, 0);
        add_row(24'sh800000, 24'sh800000, 24'sh7FFFFF, KIND_AREA, 1);
        // closed fan: three points, then four
        add_row(0, 0, 0, KIND_CLOSED, 0);
        add_row(512, 0, 0, KIND_CLOSED, 0);
        add_row(0, 512, 0, KIND_CLOSED, 1, 1, 131072, STATUS_OK);
        add_row(0, 0, 0, KIND_POLYLINE, 0);
        add_row(6, 8, 0, KIND_POLYLINE, 1, 1, 10, STATUS_OK);
        add_row(3, 3, 3, KIND_SPARE_B, 1, 1, 0, STATUS_TOO_FEW);
        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            send_point(r.x, r.y, r.z, r.kind, r.last, r.typed, r.value, r.status);
        end
        for (int i = 0; i < 4; i++)
            send_point(i[0] ? 300 : -300, i[1] ? 200 : -200, i * 50, KIND_CLOSED, i == 3);

        n = 0;
        while (n < RANDOM_POINTS) begin
            kind_pick = $urandom_range(99);
            k = kind_pick < 92 ? 3'($urandom_range(5)) : 3'($urandom_range(6, 7));
            drain = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(2, 7);
            if (n >= RANDOM_POINTS / 2 && n < RANDOM_POINTS / 2 + 8) begin
                // hold off the input until every result has drained
                @(negedge aclk);
                s_valid = 0;
                while (expected_q.size() != 0) @(posedge aclk);
            end
            for (int j = 0; j < drain; j++) begin
                if ($urandom_range(7) == 0 && j > 0)
                    send_point(pt_prev[0], pt_prev[1], pt_prev[2], 3'($urandom),
                               j == drain - 1);
                else
                    send_point(rand_coord(), rand_coord(), rand_coord(),
                               j == 0 ? k : 3'($urandom), j == drain - 1);
                n++;
            end
        end
        @(negedge aclk);
        s_valid = 0;

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);
        $display("%0d points in %0d lists, %0d results checked, %0d saturated",
                 points_sent, lists_sent, results_seen, saturated_seen);
        $display("all kinds, too-few and spare kinds, degenerate segments, full drain");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
design/plm_pkg.sv
design/plm_dpath.sv
design/plm_ctrl.sv
design/point_list_measurement_engine.sv
bench/point_list_measurement_engine_test.sv
